/* hdl/nci_pkg.sv */
package nci_pkg;

    // defaults for the top level parameters
    localparam int MAX_DEGREE_DEF   = 10;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // fixed widths
    localparam int DEGREE_W    = 4;
    localparam int STEP_W      = 32;
    localparam int WEIGHT_W    = 20;
    localparam int WEIGHT2_W   = WEIGHT_W + 1;
    localparam int DEN_W       = 20;
    localparam int DH_W        = DEGREE_W + STEP_W;
    localparam int SUM_W       = 64;
    localparam int HALF_W      = SUM_W / 2;
    localparam int WIDE_W      = SUM_W + DH_W;
    localparam int RESULT_W    = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    // Cotes table size
    localparam int TABLE_DEGREES = 10;
    localparam int TABLE_POINTS  = 11;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEGREE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP   = 2'd2;

    // reset values of the configuration registers
    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd1;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 32'h0001_0000;

    // result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_COUNT = 1'b1;

    // per-sample tags passed from front to back
    typedef struct packed {
        logic last;
        logic bad;
    } nci_flags_t;

    // closed Newton-Cotes weights, one row per degree
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_TABLE [TABLE_DEGREES][TABLE_POINTS] = '{
        '{20'sd1, 20'sd1, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
          20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0},
        '{20'sd1, 20'sd4, 20'sd1, 20'sd0, 20'sd0, 20'sd0,
          20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0},
        '{20'sd1, 20'sd3, 20'sd3, 20'sd1, 20'sd0, 20'sd0,
          20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0},
        '{20'sd7, 20'sd32, 20'sd12, 20'sd32, 20'sd7, 20'sd0,
          20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0},
        '{20'sd19, 20'sd75, 20'sd50, 20'sd50, 20'sd75, 20'sd19,
          20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0},
        '{20'sd41, 20'sd216, 20'sd27, 20'sd272, 20'sd27, 20'sd216,
          20'sd41, 20'sd0, 20'sd0, 20'sd0, 20'sd0},
        '{20'sd751, 20'sd3577, 20'sd1323, 20'sd2989, 20'sd2989, 20'sd1323,
          20'sd3577, 20'sd751, 20'sd0, 20'sd0, 20'sd0},
        '{20'sd989, 20'sd5888, -20'sd928, 20'sd10496, -20'sd4540, 20'sd10496,
          -20'sd928, 20'sd5888, 20'sd989, 20'sd0, 20'sd0},
        '{20'sd2857, 20'sd15741, 20'sd1080, 20'sd19344, 20'sd5778, 20'sd5778,
          20'sd19344, 20'sd1080, 20'sd15741, 20'sd2857, 20'sd0},
        '{20'sd16067, 20'sd106300, -20'sd48525, 20'sd272400, -20'sd260550,
          20'sd427368, -20'sd260550, 20'sd272400, -20'sd48525, 20'sd106300,
          20'sd16067}
    };

    localparam logic [DEN_W-1:0] DEN_TABLE [TABLE_DEGREES] = '{
        20'd2, 20'd6, 20'd8, 20'd90, 20'd288,
        20'd840, 20'd17280, 20'd28350, 20'd89600, 20'd598752
    };

    // weight for a place in a panel; zero outside the table
    function automatic logic signed [WEIGHT_W-1:0] cotes_weight(
        input logic [DEGREE_W-1:0] d,
        input logic [DEGREE_W-1:0] pos
    );
        logic signed [WEIGHT_W-1:0] w;
        w = '0;
        if (d != '0 && d <= DEGREE_W'(TABLE_DEGREES) && pos <= d)
        begin
            w = WEIGHT_TABLE[d - 4'd1][pos];
        end
        return w;
    endfunction

    // denominator of the rule; one outside the table
    function automatic logic [DEN_W-1:0] cotes_denominator(
        input logic [DEGREE_W-1:0] d
    );
        logic [DEN_W-1:0] den;
        den = DEN_W'(1);
        if (d != '0 && d <= DEGREE_W'(TABLE_DEGREES))
        begin
            den = DEN_TABLE[d - 4'd1];
        end
        return den;
    endfunction

endpackage

/* hdl/nci_if.sv */
// sample word channel
interface nci_sample_if #(
    parameter int SAMPLE_WIDTH = nci_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

// result word channel
interface nci_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [nci_pkg::RESULT_W-1:0]  integral;
    logic                                 status;

    modport source (output valid, output integral, output status, input ready);
    modport sink   (input valid, input integral, input status, output ready);
endinterface

// configuration write channel
interface nci_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [nci_pkg::CFG_INDEX_W-1:0]   index;
    logic [nci_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/newton_cotes_integrator.sv */
// Composite Newton-Cotes integrator, Q16.16 samples in, Q32.32 result out.
// samples : one word per abscissa, f(x_0) .. f(x_m), signed Q16.16.
// results : one word per integration, sent after sample m: integral (signed
//           Q32.32, saturated) and status (0 ok, 1 degree out of range, count
//           zero or not a multiple of the degree, integral then zero).
// cfg     : index 0 degree, 1 subinterval count m, 2 step h (Q16.16). Any
//           write to these restarts the integration; other indexes are
//           dropped. Write only while the block is idle.
// Samples are taken one per cycle while the 4-word queue has room. The
// back end does one multiply-accumulate per sample; after sample m it
// does the final scaling (two partial products, then a 100-step
// restoring divide by the rule's denominator) before it writes the
// result. Samples of the next integration are still taken until the
// queue fills.
// Reset sets degree 1, m 1, h 1.0 and clears the counters and the sum.
// A stalled result is held in the output register; the back end then
// waits before writing the next result, and the queue backs up to samples.
module newton_cotes_integrator #(
    parameter int MAX_DEGREE   = nci_pkg::MAX_DEGREE_DEF,
    parameter int COUNT_WIDTH  = nci_pkg::COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = nci_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    nci_sample_if.sink     samples,
    nci_result_if.source   results,
    nci_cfg_if.sink        cfg
);

    localparam int FLAGS_W = $bits(nci_pkg::nci_flags_t);
    localparam int ENTRY_W = SAMPLE_WIDTH + nci_pkg::WEIGHT2_W + FLAGS_W;

    logic [nci_pkg::DEGREE_W-1:0]  degree_reg, degree_next;
    logic [COUNT_WIDTH-1:0]        count_reg, count_next;
    logic [nci_pkg::STEP_W-1:0]    step_reg, step_next;
    logic                          clear;

    logic                                  q_push;
    logic                                  q_full;
    logic                                  q_pop;
    logic                                  q_valid;
    logic [ENTRY_W-1:0]                    q_wr_data;
    logic [ENTRY_W-1:0]                    q_rd_data;
    logic signed [SAMPLE_WIDTH-1:0]        f_sample;
    logic signed [nci_pkg::WEIGHT2_W-1:0]  f_weight;
    nci_pkg::nci_flags_t                   f_flags;
    logic signed [SAMPLE_WIDTH-1:0]        b_sample;
    logic signed [nci_pkg::WEIGHT2_W-1:0]  b_weight;
    nci_pkg::nci_flags_t                   b_flags;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_comb
    begin
        degree_next = degree_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        clear       = 1'b0;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                nci_pkg::REG_DEGREE:
                begin
                    degree_next = cfg.data[nci_pkg::DEGREE_W-1:0];
                    clear       = 1'b1;
                end
                nci_pkg::REG_COUNT:
                begin
                    count_next = cfg.data[COUNT_WIDTH-1:0];
                    clear      = 1'b1;
                end
                nci_pkg::REG_STEP:
                begin
                    step_next = cfg.data[nci_pkg::STEP_W-1:0];
                    clear     = 1'b1;
                end
                default:
                begin
                    clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= nci_pkg::DEGREE_RESET;
            count_reg  <= COUNT_WIDTH'(1);
            step_reg   <= nci_pkg::STEP_RESET;
        end
        else
        begin
            degree_reg <= degree_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
        end
    end

    // front: counts and classifies samples
    nci_front #(
        .MAX_DEGREE   (MAX_DEGREE),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .in_sample (samples.sample_value),
        .degree    (degree_reg),
        .count     (count_reg),
        .clear     (clear),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_sample  (f_sample),
        .q_weight  (f_weight),
        .q_flags   (f_flags)
    );

    // queue between front and back
    assign q_wr_data = {f_sample, f_weight, f_flags};

    nci_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (nci_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .rd_data   (q_rd_data),
        .not_empty (q_valid)
    );

    assign b_sample = q_rd_data[ENTRY_W-1 -: SAMPLE_WIDTH];
    assign b_weight = q_rd_data[FLAGS_W +: nci_pkg::WEIGHT2_W];
    assign b_flags  = q_rd_data[FLAGS_W-1:0];

    // back: accumulate and final scaling
    nci_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_sample     (b_sample),
        .q_weight     (b_weight),
        .q_flags      (b_flags),
        .degree       (degree_reg),
        .step         (step_reg),
        .clear        (clear),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .out_integral (results.integral),
        .out_status   (results.status)
    );

    // checks
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("front wrote a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("back read an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.status == nci_pkg::STATUS_BAD_COUNT)
        |-> (results.integral == '0))
        else $error("error word with non-zero integral");

endmodule

/* hdl/nci_front.sv */
module nci_front #(
    parameter int MAX_DEGREE   = nci_pkg::MAX_DEGREE_DEF,
    parameter int COUNT_WIDTH  = nci_pkg::COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = nci_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         in_sample,
    input  logic [nci_pkg::DEGREE_W-1:0]           degree,
    input  logic [COUNT_WIDTH-1:0]                 count,
    input  logic                                   clear,
    input  logic                                   q_full,
    output logic                                   q_push,
    output logic signed [SAMPLE_WIDTH-1:0]         q_sample,
    output logic signed [nci_pkg::WEIGHT2_W-1:0]   q_weight,
    output nci_pkg::nci_flags_t                    q_flags
);

    logic [COUNT_WIDTH-1:0]            index_reg, index_next;
    logic [nci_pkg::DEGREE_W-1:0]      pos_reg, pos_next;
    logic                              accept;
    logic                              last;
    logic                              degree_ok;
    logic                              boundary;
    logic signed [nci_pkg::WEIGHT_W-1:0] weight;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign last     = (index_reg == count);

    // classify: degree in range, count a whole number of panels
    assign degree_ok = (degree != '0) && (degree <= nci_pkg::DEGREE_W'(MAX_DEGREE));
    assign boundary  = (pos_reg == degree);

    // weight lookup, doubled on inner panel boundaries
    assign weight   = nci_pkg::cotes_weight(degree, pos_reg);
    assign q_weight = (boundary && !last) ? {weight, 1'b0} : {weight[nci_pkg::WEIGHT_W-1], weight};

    assign q_push       = accept;
    assign q_sample     = in_sample;
    assign q_flags.last = last;
    assign q_flags.bad  = !degree_ok || (count == '0) || !boundary;

    // sample and panel counters
    always_comb
    begin
        index_next = index_reg;
        pos_next   = pos_reg;
        if (clear)
        begin
            index_next = '0;
            pos_next   = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                index_next = '0;
                pos_next   = '0;
            end
            else
            begin
                index_next = index_reg + 1'b1;
                pos_next   = (pos_reg >= degree) ? nci_pkg::DEGREE_W'(1) : pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            index_reg <= index_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

/* hdl/nci_queue.sv */
module nci_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = nci_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rd_data,
    output logic              not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_data   = store_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/nci_back.sv */
module nci_back #(
    parameter int SAMPLE_WIDTH = nci_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    output logic                                   q_pop,
    input  logic signed [SAMPLE_WIDTH-1:0]         q_sample,
    input  logic signed [nci_pkg::WEIGHT2_W-1:0]   q_weight,
    input  nci_pkg::nci_flags_t                    q_flags,
    input  logic [nci_pkg::DEGREE_W-1:0]           degree,
    input  logic [nci_pkg::STEP_W-1:0]             step,
    input  logic                                   clear,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [nci_pkg::RESULT_W-1:0]    out_integral,
    output logic                                   out_status
);

    localparam int PROD_W  = SAMPLE_WIDTH + nci_pkg::WEIGHT2_W;
    localparam int EXT_W   = (PROD_W > nci_pkg::SUM_W) ? PROD_W : nci_pkg::SUM_W;
    localparam int SUM_W   = nci_pkg::SUM_W;
    localparam int HALF_W  = nci_pkg::HALF_W;
    localparam int DH_W    = nci_pkg::DH_W;
    localparam int DEN_W   = nci_pkg::DEN_W;
    localparam int WIDE_W  = nci_pkg::WIDE_W;
    localparam int PART_W  = HALF_W + DH_W;
    localparam int CNT_W   = $clog2(WIDE_W);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [6:0] {
        S_RUN    = 7'b0000001,
        S_LAST   = 7'b0000010,
        S_PREP   = 7'b0000100,
        S_MUL_LO = 7'b0001000,
        S_MUL_HI = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_SAT    = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        pv_reg, pv_next;
    nci_pkg::nci_flags_t         flags_reg, flags_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [SUM_W-1:0]            mag_reg, mag_next;
    logic                        neg_reg, neg_next;
    logic [DH_W-1:0]             dh_reg, dh_next;
    logic [DEN_W-1:0]            den_reg, den_next;
    logic [WIDE_W-1:0]           wide_reg, wide_next;
    logic [DEN_W-1:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [SUM_W-1:0]     integral_reg, integral_next;
    logic                        status_reg, status_next;

    logic signed [EXT_W-1:0]         prod_ext;
    logic [EXT_W-SUM_W:0]            prod_top;
    logic signed [SUM_W-1:0]         prod_sat;
    logic signed [SUM_W:0]           sum_wide;
    logic signed [SUM_W-1:0]         sum_acc;
    logic [HALF_W-1:0]               half;
    logic [PART_W-1:0]               part_prod;
    logic [DEN_W:0]                  rem_ext;
    logic                            rem_ge;
    logic                            quot_over;
    logic [SUM_W-1:0]                quot_lo;

    assign out_valid    = out_valid_reg;
    assign out_integral = integral_reg;
    assign out_status   = status_reg;
    assign q_pop        = (state_reg == S_RUN) && q_valid;

    // product saturated to the accumulator range
    assign prod_ext = EXT_W'(prod_reg);
    assign prod_top = prod_ext[EXT_W-1:SUM_W-1];
    assign prod_sat = ((&prod_top) || !(|prod_top)) ? prod_ext[SUM_W-1:0]
                    : (prod_ext[EXT_W-1] ? SUM_MIN : SUM_MAX);

    // saturating accumulate
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg} + {prod_sat[SUM_W-1], prod_sat};
    assign sum_acc  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                    ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];

    // shared partial product, low half then high half of the magnitude
    assign half      = (state_reg == S_MUL_LO) ? mag_reg[HALF_W-1:0] : mag_reg[SUM_W-1:HALF_W];
    assign part_prod = {{DH_W{1'b0}}, half} * {{HALF_W{1'b0}}, dh_reg};

    // restoring divide step, one quotient bit a cycle
    assign rem_ext = {rem_reg, wide_reg[WIDE_W-1]};
    assign rem_ge  = (rem_ext >= {1'b0, den_reg});

    // quotient range check
    assign quot_lo   = wide_reg[SUM_W-1:0];
    assign quot_over = (|wide_reg[WIDE_W-1:SUM_W]) || quot_lo[SUM_W-1];

    always_comb
    begin
        state_next     = state_reg;
        prod_next      = prod_reg;
        pv_next        = 1'b0;
        flags_next     = flags_reg;
        sum_next       = sum_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        dh_next        = dh_reg;
        den_next       = den_reg;
        wide_next      = wide_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        integral_next  = integral_reg;
        status_next    = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pv_reg)
        begin
            sum_next = sum_acc;
        end

        unique case (state_reg)
            S_RUN:
            begin
                if (q_valid)
                begin
                    prod_next  = q_sample * q_weight;
                    pv_next    = 1'b1;
                    flags_next = q_flags;
                    if (q_flags.last)
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                mag_next   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
                neg_next   = sum_reg[SUM_W-1];
                dh_next    = DH_W'(degree) * DH_W'(step);
                den_next   = nci_pkg::cotes_denominator(degree);
                sum_next   = '0;
                state_next = flags_reg.bad ? S_SAT : S_MUL_LO;
            end
            S_MUL_LO:
            begin
                wide_next  = WIDE_W'(part_prod);
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                wide_next  = wide_reg + WIDE_W'({part_prod, {HALF_W{1'b0}}});
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next  = rem_ge ? DEN_W'(rem_ext - {1'b0, den_reg}) : rem_ext[DEN_W-1:0];
                wide_next = {wide_reg[WIDE_W-2:0], rem_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDE_W - 1))
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (flags_reg.bad)
                    begin
                        integral_next = '0;
                        status_next   = nci_pkg::STATUS_BAD_COUNT;
                    end
                    else
                    begin
                        status_next = nci_pkg::STATUS_OK;
                        if (quot_over)
                        begin
                            integral_next = neg_reg ? SUM_MIN : SUM_MAX;
                        end
                        else
                        begin
                            integral_next = neg_reg ? (~quot_lo + 1'b1) : quot_lo;
                        end
                    end
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase

        // a register write starts a new integration
        if (clear)
        begin
            sum_next = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            pv_reg        <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        flags_reg    <= flags_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        dh_reg       <= dh_next;
        den_reg      <= den_next;
        wide_reg     <= wide_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        integral_reg <= integral_next;
        status_reg   <= status_next;
    end

endmodule
